>>> rtl/core/kshe_pkg.sv
`timescale 1ns / 1ps

package kshe_pkg;

   localparam int NUM_COLUMNS     = 4;
   localparam int NUM_ROWS        = 4;
   localparam int NUM_KEYS        = NUM_COLUMNS * NUM_ROWS;
   localparam int COL_BITS        = $clog2(NUM_COLUMNS);
   localparam int ROW_BITS        = $clog2(NUM_ROWS);
   localparam int KEY_BITS        = $clog2(NUM_KEYS);
   localparam int HOLD_COUNT_BITS = 12;
   localparam int RPT_BITS        = 8;
   localparam int LONG_BITS       = 12;
   localparam int CSR_DATA_BITS   = 12;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CMP_BITS        = (HOLD_COUNT_BITS > LONG_BITS) ? HOLD_COUNT_BITS : LONG_BITS;

   localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

   localparam logic [RPT_BITS-1:0]  RPT_RESET  = RPT_BITS'(50);
   localparam logic [LONG_BITS-1:0] LONG_RESET = LONG_BITS'(300);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_HOLD     = 1'b1;

   localparam logic KIND_REPEAT = 1'b0;
   localparam logic KIND_LONG   = 1'b1;

   localparam logic [KEY_BITS-1:0] KEY_LAST = KEY_BITS'(NUM_KEYS - 1);

   // Key code of each switch, indexed by {column, row}.
   localparam logic [KEY_BITS-1:0] KEY_MAP [NUM_KEYS] = '{
      4'd0,  4'd3,  4'd6,  4'd15,
      4'd1,  4'd4,  4'd7,  4'd9,
      4'd2,  4'd5,  4'd8,  4'd14,
      4'd10, 4'd11, 4'd12, 4'd13
   };

   typedef struct packed {
      logic load;
      logic step;
      logic key_inc;
      logic push;
      logic push_kind;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic ev_repeat;
      logic ev_long;
      logic key_last;
      logic push_ok;
      logic out_free;
   } ctl_sts_type;

endpackage

>>> rtl/core/kshe_ctrl.sv
`timescale 1ns / 1ps

module kshe_ctrl import kshe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_KEY,
      S_REP,
      S_LONG,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      rep_ff, rep_in;
   logic      long_ff, long_in;

   always_comb begin
      state_in  = state_ff;
      rep_in    = rep_ff;
      long_in   = long_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            cmd.step = 1'b1;
            rep_in   = sts.ev_repeat;
            long_in  = sts.ev_long;
            if (sts.ev_repeat || sts.ev_long) begin
               state_in = S_REP;
            end else if (sts.key_last) begin
               state_in = S_FLUSH;
            end else begin
               cmd.key_inc = 1'b1;
            end
         end
         S_REP: begin
            if (!rep_ff) begin
               state_in = S_LONG;
            end else if (sts.push_ok) begin
               cmd.push      = 1'b1;
               cmd.push_kind = KIND_REPEAT;
               state_in      = S_LONG;
            end
         end
         S_LONG: begin
            if (!long_ff || sts.push_ok) begin
               cmd.push      = long_ff;
               cmd.push_kind = KIND_LONG;
               if (sts.key_last) begin
                  state_in = S_FLUSH;
               end else begin
                  cmd.key_inc = 1'b1;
                  state_in    = S_KEY;
               end
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rep_ff   <= 1'b0;
         long_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rep_ff   <= rep_in;
         long_ff  <= long_in;
      end
   end

endmodule

>>> rtl/core/kshe_dp.sv
`timescale 1ns / 1ps

module kshe_dp import kshe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [NUM_ROWS-1:0]       req_row_sense,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  ctl_cmd_type               cmd,
   output ctl_sts_type               sts,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [COL_BITS-1:0]       rsp_next_column,
   output logic                      rsp_event_valid,
   output logic [KEY_BITS-1:0]       rsp_key_code,
   output logic                      rsp_event_kind,
   output logic                      rsp_last
);

   logic [RPT_BITS-1:0]        repeat_period_ff;
   logic [LONG_BITS-1:0]       long_hold_ff;
   logic [COL_BITS-1:0]        col_ff;
   logic [KEY_BITS-1:0]        key_ff;
   logic [NUM_KEYS-1:0]        key_down_ff, key_down_in;
   logic [NUM_KEYS-1:0]        long_fired_ff;
   logic [RPT_BITS-1:0]        rpt_cnt_ff  [NUM_KEYS];
   logic [HOLD_COUNT_BITS-1:0] hold_cnt_ff [NUM_KEYS];

   logic                       pend_valid_ff;
   logic [KEY_BITS-1:0]        pend_code_ff;
   logic                       pend_kind_ff;

   logic                       out_valid_ff;
   logic [COL_BITS-1:0]        out_col_ff;
   logic                       out_event_ff;
   logic [KEY_BITS-1:0]        out_code_ff;
   logic                       out_kind_ff;
   logic                       out_last_ff;

   logic                       hit;
   logic                       down;
   logic [RPT_BITS-1:0]        rpt_inc;
   logic [HOLD_COUNT_BITS-1:0] hold_inc;
   logic                       ev_rep;
   logic                       ev_long;
   logic [RPT_BITS-1:0]        rpt_in;
   logic                       out_free;

   // The driven column takes the first high row as its only pressed key.
   always_comb begin
      key_down_in = key_down_ff;
      hit         = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         key_down_in[KEY_MAP[{col_ff, ROW_BITS'(r)}]] = !hit && req_row_sense[r];
         hit = hit || req_row_sense[r];
      end
   end

   // Counter update for the key being visited.
   always_comb begin
      down     = key_down_ff[key_ff];
      rpt_inc  = rpt_cnt_ff[key_ff] + RPT_BITS'(1);
      hold_inc = (hold_cnt_ff[key_ff] != HOLD_MAX) ?
                 hold_cnt_ff[key_ff] + HOLD_COUNT_BITS'(1) : hold_cnt_ff[key_ff];
      ev_rep   = down && (rpt_inc >= repeat_period_ff);
      ev_long  = down && !long_fired_ff[key_ff] &&
                 (CMP_BITS'(hold_inc) >= CMP_BITS'(long_hold_ff));
      rpt_in   = ev_rep ? '0 : rpt_inc;
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      sts.ev_repeat = ev_rep;
      sts.ev_long   = ev_long;
      sts.key_last  = (key_ff == KEY_LAST);
      sts.out_free  = out_free;
      sts.push_ok   = !pend_valid_ff || out_free;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_period_ff <= RPT_RESET;
         long_hold_ff     <= LONG_RESET;
         col_ff           <= '0;
         key_ff           <= '0;
         key_down_ff      <= '0;
         long_fired_ff    <= '0;
         pend_valid_ff    <= 1'b0;
         out_valid_ff     <= 1'b0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            rpt_cnt_ff[k]  <= '0;
            hold_cnt_ff[k] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_REPEAT_PERIOD: repeat_period_ff <= csr_wdata[RPT_BITS-1:0];
               CSR_LONG_HOLD:     long_hold_ff     <= csr_wdata[LONG_BITS-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            key_down_ff   <= key_down_in;
            col_ff        <= col_ff + COL_BITS'(1);
            key_ff        <= '0;
            pend_valid_ff <= 1'b0;
         end
         if (cmd.step) begin
            if (down) begin
               rpt_cnt_ff[key_ff]    <= rpt_in;
               hold_cnt_ff[key_ff]   <= hold_inc;
               long_fired_ff[key_ff] <= long_fired_ff[key_ff] || ev_long;
            end else begin
               rpt_cnt_ff[key_ff]    <= '0;
               hold_cnt_ff[key_ff]   <= '0;
               long_fired_ff[key_ff] <= 1'b0;
            end
         end
         if (cmd.key_inc) begin
            key_ff <= key_ff + KEY_BITS'(1);
         end
         if (cmd.push) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if ((cmd.push && pend_valid_ff) || cmd.flush) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: the held event and the output stage.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pend_code_ff <= key_ff;
         pend_kind_ff <= cmd.push_kind;
      end
      if (cmd.push && pend_valid_ff) begin
         out_col_ff   <= col_ff;
         out_event_ff <= 1'b1;
         out_code_ff  <= pend_code_ff;
         out_kind_ff  <= pend_kind_ff;
         out_last_ff  <= 1'b0;
      end else if (cmd.flush) begin
         out_col_ff   <= col_ff;
         out_event_ff <= pend_valid_ff;
         out_code_ff  <= pend_valid_ff ? pend_code_ff : '0;
         out_kind_ff  <= pend_valid_ff ? pend_kind_ff : KIND_REPEAT;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_next_column = out_col_ff;
   assign rsp_event_valid = out_event_ff;
   assign rsp_key_code    = out_code_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_last        = out_last_ff;

endmodule

>>> rtl/core/keypad_scan_hold_events.sv
`timescale 1ns / 1ps
// Sequence: a tick is a load step, a visit to each of the 16 keys, a repeat and a long-hold
// step after each key with events, and a flush step. Throughput: one tick at a time; the
// single key-update path visits one key per cycle while no key has events, and a stalled
// result channel holds the tick when an event waits for the output register.
// Reset: synchronous, active high; all keys up, counts cleared, column 0, registers 50/300.

module keypad_scan_hold_events import kshe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [NUM_ROWS-1:0]       req_row_sense,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COL_BITS-1:0]       rsp_next_column,
   output logic                      rsp_event_valid,
   output logic [KEY_BITS-1:0]       rsp_key_code,
   output logic                      rsp_event_kind,
   output logic                      rsp_last,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // The controller sequences one tick: it applies the sensed rows to the driven
   // column, walks the 16 keys one per cycle while no key has events, and issues a
   // push for each event. The datapath holds the newest event back by one so that
   // the last transfer of a tick can be marked; the flush at the end releases it
   // with last set, or sends a single empty item when the tick produced no event.
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   kshe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kshe_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_row_sense   (req_row_sense),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_next_column (rsp_next_column),
      .rsp_event_valid (rsp_event_valid),
      .rsp_key_code    (rsp_key_code),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // Only one tick is in work at a time.
   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transfer taken while a tick is in work");

   // An item without an event is only ever the closing item of its tick.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_last)
      else $error("empty result item not marked last");

   // The controller issues at most one sequencing command per cycle.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.push, cmd.flush}))
      else $error("conflicting datapath commands");
`endif

endmodule
